/* design/sorc_pkg.sv */
// Shared types and constants for the span overlap run coalescer.
// No dependencies; every other file imports this package.
`default_nettype none

package sorc_pkg;

    // fixed widths of the scroll id and length fields
    localparam int FIELD_W = 32;

    // result queue depth; one item may push two words
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEMBER_SCROLL = 2'd0,
        CFG_MEMBER_START  = 2'd1,
        CFG_MEMBER_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic last_of_item;
        logic end_of_list;
        logic has_run;
        logic full_coverage;
    } res_flags_t;

endpackage

`default_nettype wire

/* design/sorc_overlap.sv */
// Per-piece overlap, run merge and result selection (combinational).
// Depends on sorc_pkg.
`default_nettype none

module sorc_overlap #(
    parameter int ADDRESS_BITS     = 48,
    parameter int TEXT_OFFSET_BITS = 32,
    localparam int SPAN_W = ((ADDRESS_BITS > sorc_pkg::FIELD_W) ?
                             ADDRESS_BITS : sorc_pkg::FIELD_W) + 1
) (
    input  logic [sorc_pkg::FIELD_W-1:0]   piece_scroll,
    input  logic [ADDRESS_BITS-1:0]        piece_start,
    input  logic [sorc_pkg::FIELD_W-1:0]   piece_length,
    input  logic                           last_piece,
    input  logic [sorc_pkg::FIELD_W-1:0]   member_scroll,
    input  logic [ADDRESS_BITS-1:0]        member_start,
    input  logic [sorc_pkg::FIELD_W-1:0]   member_length,
    input  logic [TEXT_OFFSET_BITS-1:0]    text_offset,
    input  logic                           run_pending,
    input  logic [TEXT_OFFSET_BITS-1:0]    pend_text_start,
    input  logic [TEXT_OFFSET_BITS-1:0]    pend_text_end,
    input  logic [ADDRESS_BITS-1:0]        pend_first_addr,
    input  logic [SPAN_W-1:0]              pend_end_addr,
    output logic [TEXT_OFFSET_BITS-1:0]    text_offset_next,
    output logic                           run_pending_next,
    output logic [TEXT_OFFSET_BITS-1:0]    pend_text_start_next,
    output logic [TEXT_OFFSET_BITS-1:0]    pend_text_end_next,
    output logic [ADDRESS_BITS-1:0]        pend_first_addr_next,
    output logic [SPAN_W-1:0]              pend_end_addr_next,
    output logic                           res0_valid,
    output logic [TEXT_OFFSET_BITS-1:0]    res0_start,
    output logic [TEXT_OFFSET_BITS-1:0]    res0_end,
    output sorc_pkg::res_flags_t           res0_flags,
    output logic                           res1_valid,
    output logic [TEXT_OFFSET_BITS-1:0]    res1_start,
    output logic [TEXT_OFFSET_BITS-1:0]    res1_end,
    output sorc_pkg::res_flags_t           res1_flags
);
    import sorc_pkg::*;

    logic [SPAN_W-1:0]           pa_ext;
    logic [SPAN_W-1:0]           ma_ext;
    logic [SPAN_W-1:0]           pe;
    logic [SPAN_W-1:0]           me;
    logic [ADDRESS_BITS-1:0]     lo;
    logic [SPAN_W-1:0]           lo_ext;
    logic [SPAN_W-1:0]           hi;
    logic [SPAN_W-1:0]           skip;
    logic [SPAN_W-1:0]           span;
    logic                        hit;
    logic                        overlap;
    logic [TEXT_OFFSET_BITS-1:0] at;
    logic [TEXT_OFFSET_BITS-1:0] run_end;
    logic                        cont;
    logic                        emit_mid;
    logic                        mid_full;
    logic                        fin_full;
    res_flags_t                  mid_flags;
    res_flags_t                  fin_flags;
    logic [TEXT_OFFSET_BITS-1:0] fin_start;
    logic [TEXT_OFFSET_BITS-1:0] fin_end;
    logic                        pend_after;
    logic [TEXT_OFFSET_BITS-1:0] ts_after;
    logic [TEXT_OFFSET_BITS-1:0] te_after;
    logic [ADDRESS_BITS-1:0]     fa_after;
    logic [SPAN_W-1:0]           ea_after;

    always_comb
    begin
        pa_ext = SPAN_W'(piece_start);
        ma_ext = SPAN_W'(member_start);
        pe     = pa_ext + SPAN_W'(piece_length);
        me     = ma_ext + SPAN_W'(member_length);
        hit    = (member_length != '0) && (piece_scroll == member_scroll);
        lo     = (piece_start > member_start) ? piece_start : member_start;
        lo_ext = SPAN_W'(lo);
        hi     = (pe < me) ? pe : me;
        overlap = hit && (lo_ext < hi);

        skip    = lo_ext - pa_ext;
        span    = hi - lo_ext;
        at      = text_offset + skip[TEXT_OFFSET_BITS-1:0];
        run_end = at + span[TEXT_OFFSET_BITS-1:0];

        cont     = run_pending && (pend_text_end == at) && (pend_end_addr == lo_ext);
        emit_mid = overlap && !cont && run_pending;

        // pending run as it stands after this piece
        pend_after = run_pending;
        ts_after   = pend_text_start;
        te_after   = pend_text_end;
        fa_after   = pend_first_addr;
        ea_after   = pend_end_addr;
        if (overlap)
        begin
            pend_after = 1'b1;
            te_after   = run_end;
            ea_after   = hi;
            if (!cont)
            begin
                ts_after = at;
                fa_after = lo;
            end
        end

        mid_full = (pend_first_addr == member_start) && (pend_end_addr == me);
        fin_full = (fa_after == member_start) && (ea_after == me);

        mid_flags.full_coverage = mid_full;
        mid_flags.has_run       = 1'b1;
        mid_flags.end_of_list   = 1'b0;
        mid_flags.last_of_item  = !last_piece;

        // end marker carries zero start and end when nothing is pending
        fin_flags.full_coverage = pend_after && fin_full;
        fin_flags.has_run       = pend_after;
        fin_flags.end_of_list   = 1'b1;
        fin_flags.last_of_item  = 1'b1;
        fin_start = pend_after ? ts_after : '0;
        fin_end   = pend_after ? te_after : '0;

        res0_valid = emit_mid || last_piece;
        res0_start = emit_mid ? pend_text_start : fin_start;
        res0_end   = emit_mid ? pend_text_end : fin_end;
        res0_flags = emit_mid ? mid_flags : fin_flags;
        res1_valid = emit_mid && last_piece;
        res1_start = fin_start;
        res1_end   = fin_end;
        res1_flags = fin_flags;

        text_offset_next     = last_piece ? '0 :
                               text_offset + piece_length[TEXT_OFFSET_BITS-1:0];
        run_pending_next     = pend_after && !last_piece;
        pend_text_start_next = ts_after;
        pend_text_end_next   = te_after;
        pend_first_addr_next = fa_after;
        pend_end_addr_next   = ea_after;
    end

endmodule

`default_nettype wire

/* design/sorc_res_queue.sv */
// Result word queue: takes up to two words per cycle, hands out one per cycle while head_ready is high.
// Depends on sorc_pkg.
`default_nettype none

module sorc_res_queue #(
    parameter int WIDTH = 68
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push0,
    input  logic [WIDTH-1:0] push0_data,
    input  logic             push1,
    input  logic [WIDTH-1:0] push1_data,
    output logic             room,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             head_ready
);
    import sorc_pkg::*;

    logic [WIDTH-1:0]     mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 pop;

    always_comb
    begin
        head_valid  = (count_reg != '0);
        head_data   = mem[rd_ptr_reg];
        // two free slots, regardless of a pop this cycle
        room        = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
        pop         = head_valid && head_ready;
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push0) + RES_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push0) + RES_CNT_W'(push1) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= push0_data;
        end
        if (push1)
        begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= push1_data;
        end
    end

endmodule

`default_nettype wire

/* design/span_overlap_run_coalescer_core.sv */
// Span overlap run coalescer: top level with input register, run state,
// member registers and result queue. Depends on sorc_pkg, sorc_overlap, sorc_res_queue.
// A piece taken waits in the input register until the result queue has room for it.
// Throughput: one piece per cycle while pieces yield at most one word and m_tready
// is high; a two-word piece needs two output transfers through the single-word port.
// Reset clears the member registers, the run state and the queue; no clearing pass.
`default_nettype none

module span_overlap_run_coalescer_core #(
    parameter int ADDRESS_BITS     = 48,
    parameter int TEXT_OFFSET_BITS = 32,
    localparam int IN_W   = ((2 * sorc_pkg::FIELD_W + ADDRESS_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((2 * TEXT_OFFSET_BITS + 7) / 8) * 8,
    localparam int CFG_W  = (ADDRESS_BITS > sorc_pkg::FIELD_W) ?
                            ADDRESS_BITS : sorc_pkg::FIELD_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // piece_scroll, piece_start, piece_length, zero fill
    input  logic [IN_W-1:0]                  s_tdata,
    input  logic                             s_tlast,   // last_piece
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // run_text_start, run_text_end, zero fill
    output logic [OUT_W-1:0]                 m_tdata,
    // full_coverage, has_run, last_of_item
    output logic [2:0]                       m_tuser,
    output logic                             m_tlast,   // end_of_list
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sorc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data
);
    import sorc_pkg::*;

    localparam int SPAN_W = CFG_W + 1;
    localparam int T      = TEXT_OFFSET_BITS;
    localparam int RES_W  = 2 * T + $bits(res_flags_t);

    logic                    in_valid_reg;
    logic [FIELD_W-1:0]      in_scroll_reg;
    logic [ADDRESS_BITS-1:0] in_start_reg;
    logic [FIELD_W-1:0]      in_length_reg;
    logic                    in_last_reg;

    logic [FIELD_W-1:0]      member_scroll_reg;
    logic [ADDRESS_BITS-1:0] member_start_reg;
    logic [FIELD_W-1:0]      member_length_reg;

    logic [T-1:0]            text_offset_reg;
    logic [T-1:0]            text_offset_next;
    logic                    run_pending_reg;
    logic                    run_pending_next;
    logic [T-1:0]            pend_text_start_reg;
    logic [T-1:0]            pend_text_start_next;
    logic [T-1:0]            pend_text_end_reg;
    logic [T-1:0]            pend_text_end_next;
    logic [ADDRESS_BITS-1:0] pend_first_addr_reg;
    logic [ADDRESS_BITS-1:0] pend_first_addr_next;
    logic [SPAN_W-1:0]       pend_end_addr_reg;
    logic [SPAN_W-1:0]       pend_end_addr_next;

    logic                    res0_valid;
    logic [T-1:0]            res0_start;
    logic [T-1:0]            res0_end;
    res_flags_t              res0_flags;
    logic                    res1_valid;
    logic [T-1:0]            res1_start;
    logic [T-1:0]            res1_end;
    res_flags_t              res1_flags;

    logic                    room;
    logic                    consume;
    logic                    in_take;
    logic                    head_valid;
    logic [RES_W-1:0]        head_data;
    res_flags_t              head_flags;

    assign consume   = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || consume;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_scroll_reg <= s_tdata[FIELD_W-1:0];
            in_start_reg  <= s_tdata[FIELD_W +: ADDRESS_BITS];
            in_length_reg <= s_tdata[FIELD_W + ADDRESS_BITS +: FIELD_W];
            in_last_reg   <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_scroll_reg <= '0;
            member_start_reg  <= '0;
            member_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MEMBER_SCROLL: member_scroll_reg <= cfg_data[FIELD_W-1:0];
                CFG_MEMBER_START:  member_start_reg  <= cfg_data[ADDRESS_BITS-1:0];
                CFG_MEMBER_LENGTH: member_length_reg <= cfg_data[FIELD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sorc_overlap #(
        .ADDRESS_BITS     (ADDRESS_BITS),
        .TEXT_OFFSET_BITS (TEXT_OFFSET_BITS)
    ) u_overlap (
        .piece_scroll         (in_scroll_reg),
        .piece_start          (in_start_reg),
        .piece_length         (in_length_reg),
        .last_piece           (in_last_reg),
        .member_scroll        (member_scroll_reg),
        .member_start         (member_start_reg),
        .member_length        (member_length_reg),
        .text_offset          (text_offset_reg),
        .run_pending          (run_pending_reg),
        .pend_text_start      (pend_text_start_reg),
        .pend_text_end        (pend_text_end_reg),
        .pend_first_addr      (pend_first_addr_reg),
        .pend_end_addr        (pend_end_addr_reg),
        .text_offset_next     (text_offset_next),
        .run_pending_next     (run_pending_next),
        .pend_text_start_next (pend_text_start_next),
        .pend_text_end_next   (pend_text_end_next),
        .pend_first_addr_next (pend_first_addr_next),
        .pend_end_addr_next   (pend_end_addr_next),
        .res0_valid           (res0_valid),
        .res0_start           (res0_start),
        .res0_end             (res0_end),
        .res0_flags           (res0_flags),
        .res1_valid           (res1_valid),
        .res1_start           (res1_start),
        .res1_end             (res1_end),
        .res1_flags           (res1_flags)
    );

    // advance the run state only when the piece is taken into the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_offset_reg     <= '0;
            run_pending_reg     <= 1'b0;
            pend_text_start_reg <= '0;
            pend_text_end_reg   <= '0;
            pend_first_addr_reg <= '0;
            pend_end_addr_reg   <= '0;
        end
        else if (consume)
        begin
            text_offset_reg     <= text_offset_next;
            run_pending_reg     <= run_pending_next;
            pend_text_start_reg <= pend_text_start_next;
            pend_text_end_reg   <= pend_text_end_next;
            pend_first_addr_reg <= pend_first_addr_next;
            pend_end_addr_reg   <= pend_end_addr_next;
        end
    end

    sorc_res_queue #(
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (consume && res0_valid),
        .push0_data ({res0_flags, res0_end, res0_start}),
        .push1      (consume && res1_valid),
        .push1_data ({res1_flags, res1_end, res1_start}),
        .room       (room),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_ready (m_tready)
    );

    always_comb
    begin
        head_flags = head_data[RES_W-1 -: $bits(res_flags_t)];
        m_tvalid   = head_valid;
        m_tdata    = OUT_W'(head_data[2*T-1:0]);
        m_tuser    = {head_flags.last_of_item, head_flags.has_run, head_flags.full_coverage};
        m_tlast    = head_flags.end_of_list;
    end

endmodule

`default_nettype wire
